/* src/ccpsd_pkg.sv */
package ccpsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RECORD  = 4096;
  localparam int MAX_GATE    = 256;

  localparam int SAMPLE_W  = 16;
  localparam int TRIG_W    = 12;
  localparam int CNT_W     = $clog2(MAX_RECORD);
  localparam int GATE_W    = 9;
  localparam int PRE_W     = 8;
  localparam int CFG_W     = 9;
  localparam int ACC_W     = 24;
  localparam int RATIO_W   = 18;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = ACC_W + RATIO_W + 1;
  localparam int STEP_W    = $clog2(RATIO_W);

  localparam logic [GATE_W-1:0] SHORT_GATE_RST = GATE_W'(20);
  localparam logic [GATE_W-1:0] LONG_GATE_RST  = GATE_W'(100);
  localparam logic [PRE_W-1:0]  PRE_TRIG_RST   = PRE_W'(8);

  localparam logic signed [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
  localparam logic signed [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_SHORT_GATE  = 2'd0,
    REG_LONG_GATE   = 2'd1,
    REG_PRE_TRIGGER = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [TRIG_W-1:0]          trigger_index;
    logic                       last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [RATIO_W-1:0] psd_ratio;
    logic                      accepted;
    logic signed [ACC_W-1:0]   short_integral;
    logic signed [ACC_W-1:0]   long_integral;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic test;
    logic step;
    logic load;
  } ccpsd_cmd_t;

  typedef struct packed {
    logic last_taken;
    logic div_needed;
    logic out_free;
  } ccpsd_status_t;

endpackage

/* src/ccpsd_ctrl.sv */
module ccpsd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  ccpsd_pkg::ccpsd_status_t status,
  output ccpsd_pkg::ccpsd_cmd_t    cmd
);
  import ccpsd_pkg::*;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_PREP,
    ST_TEST,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      step  <= '0;
    end else begin
      unique case (state)
        ST_ACCUM: begin
          if (status.last_taken) state <= ST_PREP;
        end
        ST_PREP: state <= ST_TEST;
        ST_TEST: begin
          if (status.div_needed) begin
            state <= ST_DIV;
            step  <= STEP_W'(RATIO_W - 1);
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (step == '0) state <= ST_DONE;
          else step <= step - 1'b1;
        end
        ST_DONE: begin
          if (status.out_free) state <= ST_ACCUM;
        end
        default: state <= ST_ACCUM;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.take = (state == ST_ACCUM);
    cmd.prep = (state == ST_PREP);
    cmd.test = (state == ST_TEST);
    cmd.step = (state == ST_DIV);
    cmd.load = (state == ST_DONE) && status.out_free;
  end

endmodule

/* src/ccpsd_dp.sv */
module ccpsd_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [ccpsd_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  input  ccpsd_pkg::in_word_t      in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ccpsd_pkg::out_word_t     out_data,
  input  ccpsd_pkg::ccpsd_cmd_t    cmd,
  output ccpsd_pkg::ccpsd_status_t status
);
  import ccpsd_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] sum;
    sum = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (sum > (ACC_W+1)'(ACC_MAX)) return ACC_MAX;
    if (sum < (ACC_W+1)'(ACC_MIN)) return ACC_MIN;
    return sum[ACC_W-1:0];
  endfunction

  // configuration
  logic [GATE_W-1:0] short_gate_len;
  logic [GATE_W-1:0] long_gate_len;
  logic [PRE_W-1:0]  pre_trigger_len;

  // accumulation
  logic [CNT_W-1:0]        sample_counter;
  logic signed [ACC_W-1:0] short_acc;
  logic signed [ACC_W-1:0] long_acc;
  logic signed [ACC_W-1:0] short_acc_next;
  logic signed [ACC_W-1:0] long_acc_next;

  // latched event sums and divider
  logic signed [ACC_W-1:0] short_total;
  logic signed [ACC_W-1:0] long_total;
  logic                    acc_flag;
  logic                    long_zero;
  logic                    long_neg;
  logic                    ovf;
  logic [NUM_W-1:0]        rem;
  logic [NUM_W-1:0]        dsh;
  logic [RATIO_W-1:0]      quo;

  logic                    take;
  logic [GATE_W-1:0]       sg;
  logic [GATE_W-1:0]       lg;
  logic [TRIG_W-1:0]       start;
  logic [CNT_W:0]          short_lim;
  logic [CNT_W:0]          long_lim;
  logic                    in_long;
  logic                    in_short;
  logic signed [ACC_W-1:0] x_ext;

  logic signed [ACC_W:0]   diff;
  logic signed [ACC_W:0]   abs_long;
  logic                    ge;
  logic signed [RATIO_W-1:0] ratio;

  assign take  = cmd.take && in_valid;
  assign sg    = (short_gate_len > GATE_W'(MAX_GATE)) ? GATE_W'(MAX_GATE) : short_gate_len;
  assign lg    = (long_gate_len > GATE_W'(MAX_GATE)) ? GATE_W'(MAX_GATE) : long_gate_len;
  assign start = (in_data.trigger_index >= TRIG_W'(pre_trigger_len)) ?
                 in_data.trigger_index - TRIG_W'(pre_trigger_len) : '0;
  assign long_lim  = (CNT_W+1)'(start) + (CNT_W+1)'(lg);
  assign short_lim = (CNT_W+1)'(start) + (CNT_W+1)'(sg);
  assign in_long   = (sample_counter >= CNT_W'(start)) &&
                     ((CNT_W+1)'(sample_counter) < long_lim);
  assign in_short  = in_long && ((CNT_W+1)'(sample_counter) < short_lim);
  assign x_ext     = ACC_W'(signed'(in_data.sample_value[SAMPLE_BITS-1:0]));

  assign long_acc_next  = in_long  ? sat_add(long_acc, x_ext)  : long_acc;
  assign short_acc_next = in_short ? sat_add(short_acc, x_ext) : short_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_gate_len  <= SHORT_GATE_RST;
      long_gate_len   <= LONG_GATE_RST;
      pre_trigger_len <= PRE_TRIG_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SHORT_GATE:  short_gate_len  <= cfg_data;
        REG_LONG_GATE:   long_gate_len   <= cfg_data;
        REG_PRE_TRIGGER: pre_trigger_len <= cfg_data[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      short_acc      <= '0;
      long_acc       <= '0;
    end else if (take) begin
      if (in_data.last_sample) begin
        sample_counter <= '0;
        short_acc      <= '0;
        long_acc       <= '0;
      end else begin
        sample_counter <= (sample_counter == CNT_W'(MAX_RECORD - 1)) ? '0 :
                          sample_counter + 1'b1;
        short_acc      <= short_acc_next;
        long_acc       <= long_acc_next;
      end
    end
  end

  // numerator (L - S) * 2^17 + |L|, divisor 2|L|, restoring one bit a step
  assign diff     = (ACC_W+1)'(long_total) - (ACC_W+1)'(short_total);
  assign abs_long = long_total[ACC_W-1] ? -(ACC_W+1)'(long_total) : (ACC_W+1)'(long_total);
  assign ge       = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (take && in_data.last_sample) begin
      short_total <= short_acc_next;
      long_total  <= long_acc_next;
    end
    if (cmd.prep) begin
      acc_flag  <= (long_total > short_total);
      long_zero <= (long_total == '0);
      long_neg  <= long_total[ACC_W-1];
      rem <= (NUM_W'(diff[ACC_W-1:0]) << (FRAC_BITS + 1)) + NUM_W'(abs_long[ACC_W-1:0]);
      dsh <= NUM_W'(abs_long[ACC_W-1:0]) << RATIO_W;
      quo <= '0;
    end
    if (cmd.test) begin
      ovf <= (rem >= {dsh[NUM_W-2:0], 1'b0});
    end
    if (cmd.step) begin
      if (ge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      quo <= {quo[RATIO_W-2:0], ge};
    end
  end

  always_comb begin
    if (!acc_flag) ratio = '0;
    else if (long_zero) ratio = RATIO_MAX;
    else if (ovf) ratio = long_neg ? RATIO_MIN : RATIO_MAX;
    else if (!long_neg) ratio = quo[RATIO_W-1] ? RATIO_MAX : signed'(quo);
    else ratio = quo[RATIO_W-1] ? RATIO_MIN : signed'(RATIO_W'(0) - quo);
  end

  assign status.last_taken = take && in_data.last_sample;
  assign status.div_needed = (long_total > short_total) && (long_total != '0) &&
                             (rem < {dsh[NUM_W-2:0], 1'b0});
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.psd_ratio      <= ratio;
      out_data.accepted       <= acc_flag;
      out_data.short_integral <= short_total;
      out_data.long_integral  <= long_total;
    end
  end

endmodule

/* src/charge_comparison_psd.sv */
// charge comparison pulse shape discrimination
//
// input channel (in_valid / in_stall / in_data): one detector sample per word,
// with the event's trigger position and a last-sample flag. ordinary samples
// are taken at one per cycle while in_stall is low; each is gated and summed
// into the short and long integrals in the cycle it arrives.
// the word carrying last_sample closes the event. from then on in_stall is
// high while the ratio 1 - short/long is formed by a restoring divider that
// produces one quotient bit per cycle. after the prep and test setup states
// it runs 18 divider steps when a division is needed; it is skipped when the
// event is not accepted, the long sum is zero or the ratio would overflow.
// output channel (out_valid / out_stall / out_data): one result word per
// event, held in a register. samples of the next event are taken while a
// result waits; a new result waits in the controller until the register
// frees, with the input stalled meanwhile.
// config writes (cfg_write / cfg_index / cfg_data) take effect at once. they
// must be made only while the block is idle; the block does not enforce this.
// rst (synchronous) restores the default gate settings, clears the sample
// counter and both accumulators and drops out_valid.
module charge_comparison_psd (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [ccpsd_pkg::CFG_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ccpsd_pkg::in_word_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ccpsd_pkg::out_word_t        out_data
);
  import ccpsd_pkg::*;

  ccpsd_cmd_t    cmd;
  ccpsd_status_t status;

  assign in_stall = !cmd.take;

  ccpsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ccpsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* src/ccpsd_chk.sv */
module ccpsd_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input ccpsd_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input ccpsd_pkg::out_word_t out_data
);
  import ccpsd_pkg::*;

  // a closing sample blocks further input while the ratio is formed
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last_sample |=> in_stall)
    else $error("input not stalled after last sample");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |-> out_data.psd_ratio == '0)
    else $error("ratio not zero on rejected event");

  a_accept_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.accepted ==
      ($signed(out_data.long_integral) > $signed(out_data.short_integral)))
    else $error("accepted flag disagrees with integrals");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind charge_comparison_psd ccpsd_chk u_ccpsd_chk (.*);
